// ===== src/triangle_face_normal_macros.svh =====
// ----------------------------------------------------------------------------
// triangle_face_normal_macros
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// Implication checked on every edge outside reset.
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal block.
// ----------------------------------------------------------------------------
package tfn_pkg;
    localparam int OUT_BITS = 16;
    localparam int CFG_BITS = 8;
endpackage

// ===== src/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: exact cross product, bit-serial integer
// square root and restoring division, each step in its own pipeline stage.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  command   start, busy, a_* .. c_*          in, busy out
//  result    out_valid, norm_*, degenerate    out
//  config    cfg_valid, cfg_ready, cfg_data   in, cfg_ready out
//
// One triangle may enter every cycle; busy is always low.
// A result passes through the square root stages (one result bit each)
// and the divider stages before the output register.
// Reset clears all valid bits and the threshold register.
// The result strobe lasts one cycle and cannot be held off.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  a_z,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic signed [COORD_BITS-1:0]  b_z,
    input  logic signed [COORD_BITS-1:0]  c_x,
    input  logic signed [COORD_BITS-1:0]  c_y,
    input  logic signed [COORD_BITS-1:0]  c_z,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_BITS-1:0]           cfg_data,
    output logic                          out_valid,
    output logic signed [OUT_BITS-1:0]    norm_x,
    output logic signed [OUT_BITS-1:0]    norm_y,
    output logic signed [OUT_BITS-1:0]    norm_z,
    output logic                          degenerate
);
    localparam int DB = COORD_BITS + 1;          // difference width
    localparam int PB = 2 * DB;                  // product width
    localparam int CB = PB + 1;                  // cross component width
    localparam int MB = CB - 1;                  // magnitude width
    localparam int QB = 2 * MB;                  // square width
    localparam int SB = QB + 2;                  // sum of squares width
    localparam int RB = SB / 2;                  // root width
    localparam int NB = RB + 2;                  // remainder width
    localparam int DV = NORMAL_FRAC_BITS + 1;    // division steps
    localparam int FB = NORMAL_FRAC_BITS + 2;    // quotient width
    localparam int SQ = RB;                      // sqrt steps
    localparam int D  = 4 + SQ + DV + 1;         // stages before output

    logic [CFG_BITS-1:0] thr_reg;
    logic [D-1:0]        vld_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            vld_reg <= {vld_reg[D-2:0], start};
        end
    end

    // Stage 1: edge vectors.
    logic signed [DB-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    always_ff @(posedge clk)
    begin
        ux_reg <= DB'(b_x) - DB'(a_x);
        uy_reg <= DB'(b_y) - DB'(a_y);
        uz_reg <= DB'(b_z) - DB'(a_z);
        vx_reg <= DB'(c_x) - DB'(a_x);
        vy_reg <= DB'(c_y) - DB'(a_y);
        vz_reg <= DB'(c_z) - DB'(a_z);
    end

    // Stage 2: six products. Stage 3: cross components.
    logic signed [PB-1:0] p_reg [6];
    logic signed [CB-1:0] e_reg [3];
    always_ff @(posedge clk)
    begin
        p_reg[0] <= PB'(uy_reg) * PB'(vz_reg);
        p_reg[1] <= PB'(uz_reg) * PB'(vy_reg);
        p_reg[2] <= PB'(uz_reg) * PB'(vx_reg);
        p_reg[3] <= PB'(ux_reg) * PB'(vz_reg);
        p_reg[4] <= PB'(ux_reg) * PB'(vy_reg);
        p_reg[5] <= PB'(uy_reg) * PB'(vx_reg);
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i] <= CB'(p_reg[2*i]) - CB'(p_reg[2*i+1]);
        end
    end

    // Stage 4: squares. Stage 5: sum.
    logic [MB-1:0] m_next [3];
    logic [QB-1:0] sq_reg [3];
    logic signed [CB-1:0] e4_reg [3];
    logic signed [CB-1:0] e5_reg [3];
    logic [SB-1:0] sum_reg;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_next[i] = e_reg[i][CB-1] ? MB'(-e_reg[i]) : MB'(e_reg[i]);
        end
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= QB'(m_next[i]) * QB'(m_next[i]);
            e4_reg[i] <= e_reg[i];
            e5_reg[i] <= e4_reg[i];
        end
        sum_reg <= SB'(sq_reg[0]) + SB'(sq_reg[1]) + SB'(sq_reg[2]);
    end

    // Square root, one result bit per stage (restoring remainder form).
    logic [SB-1:0] sn_reg  [SQ+1];
    logic [NB-1:0] sr_reg  [SQ+1];
    logic [RB-1:0] sq_root [SQ+1];
    logic signed [CB-1:0] se_reg [SQ+1][3];
    always_comb
    begin
        sn_reg[0]  = sum_reg;
        sr_reg[0]  = '0;
        sq_root[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            se_reg[0][i] = e5_reg[i];
        end
    end
    for (genvar s = 0; s < SQ; s++)
    begin : g_sqrt
        logic [NB-1:0] trial;
        logic [NB-1:0] cand;
        assign trial = {sr_reg[s][NB-3:0], sn_reg[s][SB-1 -: 2]};
        assign cand  = {sq_root[s], 2'b01};
        always_ff @(posedge clk)
        begin
            sn_reg[s+1] <= {sn_reg[s][SB-3:0], 2'b00};
            if (trial >= cand)
            begin
                sr_reg[s+1]  <= trial - cand;
                sq_root[s+1] <= {sq_root[s][RB-2:0], 1'b1};
            end
            else
            begin
                sr_reg[s+1]  <= trial;
                sq_root[s+1] <= {sq_root[s][RB-2:0], 1'b0};
            end
            se_reg[s+1] <= se_reg[s];
        end
    end

    // Division setup: magnitude, sign, degenerate flag.
    logic [RB-1:0] len;
    assign len = sq_root[SQ];
    logic          dg0_reg;
    logic [2:0]    sg_reg [DV+1];
    logic          dg_reg [DV+1];
    logic [RB-1:0] ln_reg [DV+1];
    logic [RB:0]   rm_reg [DV+1][3];
    logic [FB-1:0] qt_reg [DV+1][3];
    assign dg0_reg = (len <= RB'(thr_reg));
    always_comb
    begin
        dg_reg[0] = dg0_reg;
        ln_reg[0] = len;
        for (int i = 0; i < 3; i++)
        begin
            sg_reg[0][i] = se_reg[SQ][i][CB-1];
            // |e| <= len always, so the integer part is found by one compare.
            rm_reg[0][i] = (RB+1)'(se_reg[SQ][i][CB-1] ? MB'(-se_reg[SQ][i])
                                                      : MB'(se_reg[SQ][i]));
            qt_reg[0][i] = '0;
        end
    end
    for (genvar s = 0; s < DV; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            sg_reg[s+1] <= sg_reg[s];
            dg_reg[s+1] <= dg_reg[s];
            ln_reg[s+1] <= ln_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                if (rm_reg[s][i] >= (RB+1)'(ln_reg[s]))
                begin
                    rm_reg[s+1][i] <= (rm_reg[s][i] - (RB+1)'(ln_reg[s])) << 1;
                    qt_reg[s+1][i] <= {qt_reg[s][i][FB-2:0], 1'b1};
                end
                else
                begin
                    rm_reg[s+1][i] <= rm_reg[s][i] << 1;
                    qt_reg[s+1][i] <= {qt_reg[s][i][FB-2:0], 1'b0};
                end
            end
        end
    end

    // Rounding, clamp and output register.
    localparam logic [FB-1:0] ONE = FB'(1) << NORMAL_FRAC_BITS;
    logic [FB-1:0]        rq_next [3];
    logic signed [FB-1:0] sv_next [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rq_next[i] = qt_reg[DV][i] +
                FB'(rm_reg[DV][i] >= (RB+1)'(ln_reg[DV]));
            if (rq_next[i] > ONE)
            begin
                rq_next[i] = ONE;
            end
            sv_next[i] = sg_reg[DV][i] ? -rq_next[i] : rq_next[i];
        end
    end

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] nx_reg, ny_reg, nz_reg;
    logic                dgo_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[D-1];
        end
    end
    always_ff @(posedge clk)
    begin
        dgo_reg <= dg_reg[DV];
        if (dg_reg[DV])
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= OUT_BITS'(ONE);
        end
        else
        begin
            nx_reg <= OUT_BITS'(sv_next[0]);
            ny_reg <= OUT_BITS'(sv_next[1]);
            nz_reg <= OUT_BITS'(sv_next[2]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_x     = nx_reg;
    assign norm_y     = ny_reg;
    assign norm_z     = nz_reg;
    assign degenerate = dgo_reg;
endmodule

// ===== src/tfn_checker.sv =====
`timescale 1ns / 1ps
`include "triangle_face_normal_macros.svh"
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the triangle face normal block.
// ----------------------------------------------------------------------------
module tfn_checker
    import tfn_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       busy,
    input logic                       cfg_ready,
    input logic                       out_valid,
    input logic signed [OUT_BITS-1:0] norm_x,
    input logic signed [OUT_BITS-1:0] norm_y,
    input logic signed [OUT_BITS-1:0] norm_z,
    input logic                       degenerate
);
    `TFN_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy && cfg_ready, "block stalled")
    `TFN_ASSERT_IMP(a_fallback, clk, rst_n, out_valid && degenerate, norm_x == 0 && norm_y == 0 && norm_z == 16384, "fallback normal is not (0,0,1)")
    `TFN_ASSERT_IMP(a_range, clk, rst_n, out_valid && !degenerate, norm_x >= -16384 && norm_x <= 16384 && norm_y >= -16384 && norm_y <= 16384, "normal component out of range")
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
);

// ===== test/tfn_normal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_normal_checker
// Watches the command, result and threshold channels of the face normal
// block. Each accepted triangle is turned into its expected unit normal with
// exact wide integer arithmetic. Results are compared in order.
// ----------------------------------------------------------------------------
module tfn_normal_checker
    import tfn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic signed [15:0]         a_x,
    input  logic signed [15:0]         a_y,
    input  logic signed [15:0]         a_z,
    input  logic signed [15:0]         b_x,
    input  logic signed [15:0]         b_y,
    input  logic signed [15:0]         b_z,
    input  logic signed [15:0]         c_x,
    input  logic signed [15:0]         c_y,
    input  logic signed [15:0]         c_z,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_BITS-1:0]        cfg_data,
    input  logic                       out_valid,
    input  logic signed [OUT_BITS-1:0] norm_x,
    input  logic signed [OUT_BITS-1:0] norm_y,
    input  logic signed [OUT_BITS-1:0] norm_z,
    input  logic                       degenerate,
    output int                         mismatches,
    output int                         pending
);
    localparam int FRAC_BITS = 14;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        logic                       degen;
    } normal_t;

    normal_t           normals_due[$];
    logic [CFG_BITS-1:0] min_length;

    // Rounded |c| * 2^14 / len with ties away from zero, clamped, signed as c.
    function automatic logic [OUT_BITS-1:0] scale_comp(input longint c,
                                                        input logic [127:0] len);
        logic [127:0] mag;
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        mag = (c < 0) ? -c : c;
        num = mag << FRAC_BITS;
        q = num / len;
        r = num % len;
        if ((r << 1) >= len)
            q = q + 1;
        if (q > (128'd1 << FRAC_BITS))
            q = 128'd1 << FRAC_BITS;
        if (c < 0)
            q = -q;
        return q[OUT_BITS-1:0];
    endfunction

    function automatic normal_t predict_normal(input logic signed [15:0] p [9],
                                               input logic [CFG_BITS-1:0] thr);
        longint ux, uy, uz, vx, vy, vz, ex, ey, ez;
        logic [127:0] sum;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] m;
        normal_t n;
        ux = longint'(p[3]) - longint'(p[0]);
        uy = longint'(p[4]) - longint'(p[1]);
        uz = longint'(p[5]) - longint'(p[2]);
        vx = longint'(p[6]) - longint'(p[0]);
        vy = longint'(p[7]) - longint'(p[1]);
        vz = longint'(p[8]) - longint'(p[2]);
        ex = uy * vz - uz * vy;
        ey = uz * vx - ux * vz;
        ez = ux * vy - uy * vx;
        sum = '0;
        m = (ex < 0) ? -ex : ex;
        sum = sum + m * m;
        m = (ey < 0) ? -ey : ey;
        sum = sum + m * m;
        m = (ez < 0) ? -ez : ez;
        sum = sum + m * m;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum)
                root = cand;
        end
        if (root <= 128'(thr))
        begin
            n.x = '0;
            n.y = '0;
            n.z = OUT_BITS'(1 << FRAC_BITS);
            n.degen = 1'b1;
        end
        else
        begin
            n.x = scale_comp(ex, root);
            n.y = scale_comp(ey, root);
            n.z = scale_comp(ez, root);
            n.degen = 1'b0;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] p [9];
        normal_t exp_n;
        if (!rst_n)
        begin
            min_length <= '0;
            mismatches <= 0;
            pending    <= 0;
            normals_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                min_length <= cfg_data;
            if (start && !busy)
            begin
                p = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
                normals_due.insert(normals_due.size(), predict_normal(p, min_length));
            end
            if (out_valid)
            begin
                if (normals_due.size() == 0)
                begin
                    $display("%0t: unexpected word %h %h %h %b", $time,
                             norm_x, norm_y, norm_z, degenerate);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_n = normals_due.pop_front();
                    if (exp_n.x !== norm_x || exp_n.y !== norm_y
                        || exp_n.z !== norm_z || exp_n.degen !== degenerate)
                    begin
                        $display("%0t: expected %h %h %h %b, actual %h %h %h %b",
                                 $time, exp_n.x, exp_n.y, exp_n.z, exp_n.degen,
                                 norm_x, norm_y, norm_z, degenerate);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= normals_due.size();
        end
    end
endmodule

// ===== test/tb_triangle_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal
// Drives directed and random triangles into the face normal block across
// several threshold settings, with random idle cycles, and reports the
// verdict from the checker.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal;
    import tfn_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] a_x = 0, a_y = 0, a_z = 0;
    logic signed [15:0] b_x = 0, b_y = 0, b_z = 0;
    logic signed [15:0] c_x = 0, c_y = 0, c_z = 0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic out_valid;
    logic signed [OUT_BITS-1:0] norm_x, norm_y, norm_z;
    logic degenerate;
    int mismatches;
    int pending;
    bit quiet;

    always #5 clk = ~clk;

    triangle_face_normal u_top (.*);

    tfn_normal_checker u_checker (.*);

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_tri(input logic signed [15:0] p [9]);
        if (!quiet && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        {a_x, a_y, a_z} <= {p[0], p[1], p[2]};
        {b_x, b_y, b_z} <= {p[3], p[4], p[5]};
        {c_x, c_y, c_z} <= {p[6], p[7], p[8]};
        do @(posedge clk); while (busy);
    endtask

    // Lets the pipeline empty, before each threshold change and once mid-phase.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_BITS-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_tri();
        logic signed [15:0] p [9];
        int span;
        case ($urandom_range(3))
            0: span = 0;
            1: span = 16;
            2: span = 300;
            default: span = 4000;
        endcase
        for (int i = 0; i < 3; i++)
            p[i] = 16'($urandom);
        for (int i = 3; i < 9; i++)
            p[i] = (span == 0) ? 16'($urandom)
                 : 16'(p[i % 3] + $signed($urandom_range(2 * span)) - span);
        send_tri(p);
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] thr [5];
        logic signed [15:0] d [9];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset threshold.
        d = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_tri(d);
        d = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                       send_tri(d);
        d = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                       send_tri(d);
        d = '{0, 0, 0, 0, 0, 1, 1, 0, 0};                       send_tri(d);
        d = '{-32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, 32767};                            send_tri(d);
        d = '{32767, 32767, 32767, -32768, 32767, -32768,
              32767, -32768, -32768};                           send_tri(d);
        d = '{-32768, -32768, -32768, 32767, 32767, 32767,
              0, 0, 0};                                         send_tri(d);
        d = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                       send_tri(d);
        d = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};              send_tri(d);
        d = '{0, 0, 0, 3, 0, 0, 0, 5, 0};                       send_tri(d);
        d = '{0, 0, 0, 1, 1, 0, 1, 2, 1};                       send_tri(d);
        d = '{100, -200, 300, -400, 500, -600, 700, 800, -900}; send_tri(d);
        d = '{0, 0, 0, 32767, 0, 0, 0, 32767, 1};               send_tri(d);

        thr = '{8'd255, 8'd1, 8'($urandom), 8'd0, 8'd17};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thr[ph]);
            if (ph == 0)
            begin
                d = '{0, 0, 0, 16, 0, 0, 0, 16, 0}; send_tri(d);
                d = '{0, 0, 0, 15, 0, 0, 0, 17, 0}; send_tri(d);
                d = '{0, 0, 0, 16, 0, 0, 0, 15, 0}; send_tri(d);
            end
            for (int n = 0; n < 130; n++)
            begin
                quiet = (ph == 2 && n >= 20 && n < 110);
                if (ph == 3 && n == 65)
                    settle();
                random_tri();
            end
            quiet = 1'b0;
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== triangle_face_normal.f =====
+incdir+src
src/tfn_pkg.sv
src/triangle_face_normal.sv
src/tfn_checker.sv
test/tfn_normal_checker.sv
test/tb_triangle_face_normal.sv
